@@ rtl/stc_pkg.sv @@
// Shared constants, types and register codes for the spike threshold capture block.
`timescale 1ns / 1ps

package stc_pkg;

  localparam int unsigned PreSamples        = 16;
  localparam int unsigned PostSamples       = 32;
  localparam int unsigned RingDepth         = 64;
  localparam int unsigned RefractorySamples = 5;
  localparam int unsigned WindowMax         = 48;
  localparam int unsigned WinLen =
      (PreSamples + PostSamples > WindowMax) ? WindowMax : PreSamples + PostSamples;
  localparam int unsigned RingAw = $clog2(RingDepth);

  localparam logic signed [15:0] ThresholdReset = -16'sd3277;
  localparam logic [15:0]        WindowLenReset = 16'd44100;
  localparam logic [6:0]         CrestReset     = 7'd48;

  // Register indexes on the configuration port.
  localparam logic [2:0] RegThreshold = 3'd0;
  localparam logic [2:0] RegAutoHigh  = 3'd1;
  localparam logic [2:0] RegAutoLow   = 3'd2;
  localparam logic [2:0] RegCrest     = 3'd3;
  localparam logic [2:0] RegWinLen    = 3'd4;
  localparam logic [2:0] RegChannel   = 3'd5;

  typedef struct packed {
    logic               hi_en;
    logic               lo_en;
    logic [6:0]         crest;
    logic [15:0]        win_len;
    logic [5:0]         channel;
    logic               thr_wr;
    logic signed [15:0] thr_val;
  } cfg_t;

  // One classified sample handed from the front end to the back end.
  typedef struct packed {
    logic signed [15:0] sample;
    logic               emit;
    logic [31:0]        frame;
  } qentry_t;

  typedef struct packed {
    logic               start;
    logic signed [32:0] sum;
    logic [46:0]        sumsq;
    logic [15:0]        count;
    logic [6:0]         crest;
    logic               neg;
  } est_req_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic signed [15:0] thr;
  } est_rsp_t;

endpackage

@@ rtl/spike_threshold_capture_core.sv @@
// Top level of the spike threshold capture block: register file and wiring.
`timescale 1ns / 1ps

// Every accepted sample comes back first as a passthrough result (tuser 0);
// a downward crossing of the active threshold, outside the refractory time,
// makes the sample POST_SAMPLES later also return the 48-sample window that
// starts PRE_SAMPLES before the crossing, oldest first, tagged with the
// frame count and channel (tuser 1); tlast marks the final result of each
// input. The front end takes one sample per cycle, while the queue has room,
// into a four-entry queue; the back end sends a passthrough straight from the
// queue and reads each window sample from the history ring through a
// registered read before sending it. When automatic threshold is enabled,
// the sample that closes an estimate window starts an iterative unit
// (32-step multiply, 32-step square root, 39-step divide) and no new sample
// is taken until the new threshold is in place.
// No clearing pass runs after reset; the ring holds per-entry valid bits.

module spike_threshold_capture_core (
  input  logic        clk,
  input  logic        rst,
  // APB-style configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Sample input
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [15:0] sample_in
  // Result output
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // [15:0] out_sample, [47:16] spike_time, [53:48] spike_channel
  output logic [0:0]  m_tuser,   // [0] out_kind
  output logic        m_tlast    // last_of_run
);

  logic signed [15:0] threshold_level;
  logic               auto_high_enable;
  logic               auto_low_enable;
  logic [6:0]         crest_factor_q4;
  logic [15:0]        auto_window_len;
  logic [5:0]         channel_number;

  logic               wr_en;
  logic [2:0]         wr_idx;

  stc_pkg::cfg_t      cfg;
  stc_pkg::qentry_t   q_in;
  stc_pkg::qentry_t   q_out;
  logic               q_push;
  logic               q_pop;
  logic               q_full;
  logic               q_empty;
  stc_pkg::est_req_t  est_req;
  stc_pkg::est_rsp_t  est_rsp;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign wr_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold_level  <= stc_pkg::ThresholdReset;
      auto_high_enable <= 1'b0;
      auto_low_enable  <= 1'b0;
      crest_factor_q4  <= stc_pkg::CrestReset;
      auto_window_len  <= stc_pkg::WindowLenReset;
      channel_number   <= '0;
    end else if (wr_en) begin
      case (wr_idx)
        stc_pkg::RegThreshold: threshold_level  <= pwdata[15:0];
        stc_pkg::RegAutoHigh:  auto_high_enable <= pwdata[0];
        stc_pkg::RegAutoLow:   auto_low_enable  <= pwdata[0];
        stc_pkg::RegCrest:     crest_factor_q4  <= pwdata[6:0];
        stc_pkg::RegWinLen:    auto_window_len  <= pwdata[15:0];
        stc_pkg::RegChannel:   channel_number   <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (wr_idx)
      stc_pkg::RegThreshold: prdata = {16'b0, threshold_level};
      stc_pkg::RegAutoHigh:  prdata = {31'b0, auto_high_enable};
      stc_pkg::RegAutoLow:   prdata = {31'b0, auto_low_enable};
      stc_pkg::RegCrest:     prdata = {25'b0, crest_factor_q4};
      stc_pkg::RegWinLen:    prdata = {16'b0, auto_window_len};
      stc_pkg::RegChannel:   prdata = {26'b0, channel_number};
      default:               prdata = '0;
    endcase
  end

  // A write of the manual level also reloads the active threshold.
  assign cfg.hi_en   = auto_high_enable;
  assign cfg.lo_en   = auto_low_enable;
  assign cfg.crest   = crest_factor_q4;
  assign cfg.win_len = auto_window_len;
  assign cfg.channel = channel_number;
  assign cfg.thr_wr  = wr_en && (wr_idx == stc_pkg::RegThreshold);
  assign cfg.thr_val = pwdata[15:0];

  stc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .cfg      (cfg),
    .q_push   (q_push),
    .q_entry  (q_in),
    .q_full   (q_full),
    .est_req  (est_req),
    .est_rsp  (est_rsp)
  );

  stc_estimator u_est (
    .clk (clk),
    .rst (rst),
    .req (est_req),
    .rsp (est_rsp)
  );

  stc_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (q_in),
    .pop   (q_pop),
    .dout  (q_out),
    .full  (q_full),
    .empty (q_empty)
  );

  stc_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_entry  (q_out),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .channel  (channel_number),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  // The estimator is only started from idle, and no sample enters while
  // it runs.
  a_est_start_idle: assert property (@(posedge clk) disable iff (rst)
    est_req.start |-> !est_rsp.busy) else $error("estimator started while busy");

  a_est_blocks_input: assert property (@(posedge clk) disable iff (rst)
    est_req.start |=> !s_tready) else $error("input taken during estimate");

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    est_rsp.done |-> $past(est_rsp.busy)) else $error("estimate done without run");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full) else $error("queue overflow");

endmodule

@@ rtl/stc_fifo.sv @@
// Small request queue between the front end and the back end.
`timescale 1ns / 1ps

module stc_fifo (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  stc_pkg::qentry_t din,
  input  logic             pop,
  output stc_pkg::qentry_t dout,
  output logic             full,
  output logic             empty
);

  stc_pkg::qentry_t slots [4];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [2:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 2'd1;
      if (pop)  rd_ptr <= rd_ptr + 2'd1;
      count <= count + {2'b0, push} - {2'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= din;
  end

  assign dout  = slots[rd_ptr];
  assign full  = (count == 3'd4);
  assign empty = (count == 3'd0);

endmodule

@@ rtl/stc_estimator.sv @@
// Multi-cycle unit that turns the window sums into a crest-scaled threshold.
`timescale 1ns / 1ps

module stc_estimator (
  input  logic               clk,
  input  logic               rst,
  input  stc_pkg::est_req_t  req,
  output stc_pkg::est_rsp_t  rsp
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MUL   = 3'd1;
  localparam logic [2:0] S_SUB   = 3'd2;
  localparam logic [2:0] S_SQRT  = 3'd3;
  localparam logic [2:0] S_SCALE = 3'd4;
  localparam logic [2:0] S_DIV   = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0]  state;
  logic [5:0]  step;
  logic [15:0] n_sh;
  logic [31:0] mag_sh;
  logic [63:0] sq_add;
  logic [63:0] mg_add;
  logic [63:0] ns_acc;
  logic [63:0] s2_acc;
  logic [63:0] v;
  logic [63:0] res;
  logic [63:0] bitv;
  logic [15:0] n_keep;
  logic [6:0]  crest;
  logic        neg;
  logic [38:0] quo;
  logic [20:0] rem;
  logic signed [15:0] thr;
  logic        done;

  logic [31:0] mag_in;
  logic [63:0] sqrt_try;
  logic [20:0] rem_sh;
  logic [19:0] den;

  assign mag_in   = req.sum[32] ? 32'(-req.sum) : req.sum[31:0];
  assign sqrt_try = res + bitv;
  assign rem_sh   = {rem[19:0], quo[38]};
  assign den      = {n_keep, 4'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: if (req.start) state <= S_MUL;
        S_MUL:  if (step == 6'd31) state <= S_SUB;
        S_SUB:  state <= S_SQRT;
        S_SQRT: if (step == 6'd31) state <= S_SCALE;
        S_SCALE: state <= S_DIV;
        S_DIV: if (step == 6'd38) state <= S_DONE;
        S_DONE: begin
          state <= S_IDLE;
          done  <= 1'b1;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        step   <= '0;
        n_sh   <= req.count;
        n_keep <= req.count;
        mag_sh <= mag_in;
        sq_add <= {17'b0, req.sumsq};
        mg_add <= {32'b0, mag_in};
        ns_acc <= '0;
        s2_acc <= '0;
        crest  <= req.crest;
        neg    <= req.neg;
      end
      S_MUL: begin
        if (n_sh[0])   ns_acc <= ns_acc + sq_add;
        if (mag_sh[0]) s2_acc <= s2_acc + mg_add;
        n_sh   <= n_sh >> 1;
        mag_sh <= mag_sh >> 1;
        sq_add <= sq_add << 1;
        mg_add <= mg_add << 1;
        step   <= (step == 6'd31) ? 6'd0 : step + 6'd1;
      end
      S_SUB: begin
        v    <= (ns_acc >= s2_acc) ? ns_acc - s2_acc : 64'd0;
        res  <= '0;
        bitv <= 64'h4000_0000_0000_0000;
      end
      S_SQRT: begin
        if (v >= sqrt_try) begin
          v   <= v - sqrt_try;
          res <= (res >> 1) + bitv;
        end else begin
          res <= res >> 1;
        end
        bitv <= bitv >> 2;
        step <= (step == 6'd31) ? 6'd0 : step + 6'd1;
      end
      S_SCALE: begin
        // Rounded crest * std: (crest * r + 8n) / (16n).
        quo <= 39'(crest) * 39'(res[31:0]) + {20'b0, n_keep, 3'b0};
        rem <= '0;
      end
      S_DIV: begin
        if (rem_sh >= {1'b0, den}) begin
          rem <= rem_sh - {1'b0, den};
          quo <= {quo[37:0], 1'b1};
        end else begin
          rem <= rem_sh;
          quo <= {quo[37:0], 1'b0};
        end
        step <= step + 6'd1;
      end
      S_DONE: begin
        if (neg) thr <= (quo > 39'd32768) ? -16'sd32768 : 16'(-quo);
        else     thr <= (quo > 39'd32767) ? 16'sd32767 : 16'(quo);
      end
      default: step <= '0;
    endcase
  end

  assign rsp.busy = (state != S_IDLE);
  assign rsp.done = done;
  assign rsp.thr  = thr;

endmodule

@@ rtl/stc_front.sv @@
// Front end: accepts samples, runs the crossing detector and the window sums.
`timescale 1ns / 1ps

module stc_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [15:0]        s_tdata,
  input  stc_pkg::cfg_t      cfg,
  output logic               q_push,
  output stc_pkg::qentry_t   q_entry,
  input  logic               q_full,
  output stc_pkg::est_req_t  est_req,
  input  stc_pkg::est_rsp_t  est_rsp
);

  logic signed [15:0] prev;
  logic               pend_armed;
  logic [5:0]         pend_cnt;
  logic [2:0]         refr;
  logic [31:0]        frame;
  logic signed [15:0] thr;
  logic               auto_armed;
  logic [15:0]        auto_rem;
  logic [15:0]        auto_cnt;
  logic signed [32:0] run_sum;
  logic [46:0]        run_sq;
  logic [6:0]         lat_crest;
  logic               lat_neg;

  logic               accept;
  logic signed [15:0] x;
  logic               arm_now;
  logic               armed0;
  logic [15:0]        rem0, rem1, cnt0, cnt1;
  logic signed [32:0] sum0, sum1;
  logic [46:0]        sq0, sq1;
  logic signed [31:0] xx;
  logic               add_now;
  logic               finish;
  logic               emit;

  assign x        = s_tdata;
  // The cycle that carries a finished estimate still holds the old threshold.
  assign s_tready = !q_full && !est_rsp.busy && !est_rsp.done;
  assign accept   = s_tvalid && s_tready;
  assign xx       = x * x;

  always_comb begin
    arm_now = !auto_armed && (cfg.hi_en || cfg.lo_en);
    armed0  = auto_armed || arm_now;
    rem0    = arm_now ? cfg.win_len : auto_rem;
    cnt0    = arm_now ? 16'd0 : auto_cnt;
    sum0    = arm_now ? 33'sd0 : run_sum;
    sq0     = arm_now ? 47'd0 : run_sq;
    add_now = armed0 && (rem0 != 16'd0);
    rem1    = add_now ? rem0 - 16'd1 : rem0;
    cnt1    = add_now ? cnt0 + 16'd1 : cnt0;
    sum1    = add_now ? sum0 + 33'(x) : sum0;
    sq1     = add_now ? sq0 + {15'b0, xx[31:0]} : sq0;
    finish  = armed0 && (rem1 == 16'd0);
    emit    = pend_armed && (pend_cnt == 6'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev       <= '0;
      pend_armed <= 1'b0;
      pend_cnt   <= '0;
      refr       <= '0;
      frame      <= '0;
      thr        <= stc_pkg::ThresholdReset;
      auto_armed <= 1'b0;
      auto_rem   <= '0;
      auto_cnt   <= '0;
      run_sum    <= '0;
      run_sq     <= '0;
      lat_crest  <= '0;
      lat_neg    <= 1'b0;
    end else begin
      if (cfg.thr_wr) thr <= cfg.thr_val;
      else if (est_rsp.done) thr <= est_rsp.thr;
      if (accept) begin
        auto_armed <= armed0 && !finish;
        auto_rem   <= rem1;
        auto_cnt   <= cnt1;
        run_sum    <= sum1;
        run_sq     <= sq1;
        if (arm_now) begin
          lat_crest <= cfg.crest;
          lat_neg   <= cfg.lo_en;
        end
        priority if (pend_armed && pend_cnt != 6'd0) begin
          pend_cnt <= pend_cnt - 6'd1;
        end else if (emit) begin
          pend_armed <= 1'b0;
          refr       <= 3'(stc_pkg::RefractorySamples);
        end else if (refr != 3'd0) begin
          refr <= refr - 3'd1;
        end else if (prev > thr && x < thr) begin
          pend_armed <= 1'b1;
          pend_cnt   <= 6'(stc_pkg::PostSamples - 1);
        end
        frame <= frame + 32'd1;
        prev  <= x;
      end
    end
  end

  assign q_push         = accept;
  assign q_entry.sample = x;
  assign q_entry.emit   = emit;
  assign q_entry.frame  = frame;

  // The request carries the sums with the closing sample already added, taken
  // straight from the adders; the estimator latches them as it starts.
  assign est_req.start = accept && finish && (cnt1 != 16'd0);
  assign est_req.sum   = sum1;
  assign est_req.sumsq = sq1;
  assign est_req.count = cnt1;
  assign est_req.crest = arm_now ? cfg.crest : lat_crest;
  assign est_req.neg   = arm_now ? cfg.lo_en : lat_neg;

endmodule

@@ rtl/stc_back.sv @@
// Back end: history ring, passthrough output and spike window readout.
`timescale 1ns / 1ps

module stc_back (
  input  logic             clk,
  input  logic             rst,
  input  stc_pkg::qentry_t q_entry,
  input  logic             q_empty,
  output logic             q_pop,
  input  logic [5:0]       channel,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [55:0]      m_tdata,
  output logic [0:0]       m_tuser,
  output logic             m_tlast
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RD   = 2'd1;
  localparam logic [1:0] S_SEND = 2'd2;

  logic [15:0] ring [stc_pkg::RingDepth];
  logic [stc_pkg::RingDepth-1:0] ring_valid;
  logic [15:0] rd_data;
  logic        rd_valid;

  logic [1:0]  state;
  logic [5:0]  idx;
  logic [stc_pkg::RingAw-1:0] base;
  logic [31:0] win_time;

  logic               o_kind;
  logic signed [15:0] o_sample;
  logic [31:0]        o_time;
  logic [5:0]         o_chan;
  logic               o_last;

  logic        out_free;
  logic [stc_pkg::RingAw-1:0] raddr;
  logic [stc_pkg::RingAw-1:0] waddr;
  logic        idx_last;

  assign out_free = !m_tvalid || m_tready;
  assign q_pop    = (state == S_IDLE) && !q_empty && out_free;
  assign raddr    = base + idx[stc_pkg::RingAw-1:0];
  assign waddr    = q_entry.frame[stc_pkg::RingAw-1:0];
  assign idx_last = (idx == 6'(stc_pkg::WinLen - 1));

  always_ff @(posedge clk) begin
    if (q_pop) ring[waddr] <= q_entry.sample;
    if (state == S_RD) rd_data <= ring[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ring_valid <= '0;
      rd_valid   <= 1'b0;
    end else begin
      if (q_pop) ring_valid[waddr] <= 1'b1;
      if (state == S_RD) rd_valid <= ring_valid[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
      idx      <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (q_pop) begin
            m_tvalid <= 1'b1;
            idx      <= '0;
            if (q_entry.emit) state <= S_RD;
          end else if (m_tready) begin
            m_tvalid <= 1'b0;
          end
        end
        S_RD: begin
          state <= S_SEND;
          if (m_tready) m_tvalid <= 1'b0;
        end
        S_SEND: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            idx      <= idx + 6'd1;
            state    <= idx_last ? S_IDLE : S_RD;
          end
        end
        default: begin
          state    <= S_IDLE;
          m_tvalid <= 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      o_kind   <= 1'b0;
      o_sample <= q_entry.sample;
      o_time   <= '0;
      o_chan   <= '0;
      o_last   <= !q_entry.emit;
      base     <= waddr - stc_pkg::RingAw'(stc_pkg::WinLen);
      win_time <= q_entry.frame;
    end else if (state == S_SEND && out_free) begin
      o_kind   <= 1'b1;
      o_sample <= rd_valid ? rd_data : 16'd0;
      o_time   <= win_time;
      o_chan   <= channel;
      o_last   <= idx_last;
    end
  end

  assign m_tdata = {2'b0, o_chan, o_time, o_sample};
  assign m_tuser = o_kind;
  assign m_tlast = o_last;

endmodule

@@ dv/tb_top.sv @@
// Self-checking testbench for the spike threshold capture core.
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned IdleLimit = 5000;
  localparam int unsigned SettleCycles = 300;

  typedef struct {
    logic               kind;
    logic signed [15:0] sample;
    logic [31:0]        stime;
    logic [5:0]         chan;
    logic               last;
  } spike_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [55:0] m_tdata;
  logic [0:0]  m_tuser;
  logic        m_tlast;

  spike_threshold_capture_core dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tuser(m_tuser), .m_tlast(m_tlast)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Samples waiting to be sent and the results the detector should produce.
  logic [15:0]   sample_queue[$];
  spike_result_t expected_results[$];
  int unsigned   mismatch_count = 0;
  int unsigned   idle_cycles = 0;
  int unsigned   src_gap = 0;
  int unsigned   sink_gap = 0;
  bit            calm = 1'b0;

  // Shadow copies of the configuration registers.
  logic signed [15:0] cfg_threshold = stc_pkg::ThresholdReset;
  logic               cfg_auto_high = 1'b0;
  logic               cfg_auto_low = 1'b0;
  logic [6:0]         cfg_crest = stc_pkg::CrestReset;
  logic [15:0]        cfg_win_len = stc_pkg::WindowLenReset;
  logic [5:0]         cfg_channel = '0;

  // Shadow copy of the detector state.
  logic [15:0]        history[stc_pkg::RingDepth];
  logic signed [15:0] prev_sample = '0;
  int                 countdown = -1;
  int                 refractory = 0;
  logic [31:0]        frame_count = '0;
  logic signed [15:0] live_threshold = stc_pkg::ThresholdReset;
  bit                 est_armed = 1'b0;
  int unsigned        est_remaining = 0;
  int unsigned        est_count = 0;
  longint             est_sum = 0;
  longint unsigned    est_sumsq = 0;
  logic [6:0]         est_crest = '0;
  bit                 est_negative = 1'b0;

  initial begin
    foreach (history[i]) history[i] = '0;
  end

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res;
    longint unsigned bitval;
    res = 0;
    bitval = 64'd1 << 62;
    while (bitval > v) bitval >>= 2;
    while (bitval != 0) begin
      if (v >= res + bitval) begin
        v -= res + bitval;
        res = (res >> 1) + bitval;
      end else begin
        res >>= 1;
      end
      bitval >>= 2;
    end
    return res;
  endfunction

  // Closes one estimate: threshold = +/- crest * standard deviation, rounded.
  function automatic void close_estimate();
    longint unsigned n, mag_sum, s2, ns, d, r, mag;
    n = est_count;
    if (n == 0) return;
    mag_sum = (est_sum < 0) ? longint'(-est_sum) : longint'(est_sum);
    s2 = mag_sum * mag_sum;
    ns = n * est_sumsq;
    d = (ns >= s2) ? ns - s2 : 0;
    r = int_sqrt(d);
    mag = (longint'(est_crest) * r + 8 * n) / (16 * n);
    if (est_negative) live_threshold = (mag > 32768) ? -16'sd32768 : -16'(mag);
    else live_threshold = (mag > 32767) ? 16'sd32767 : 16'(mag);
  endfunction

  // Advances the shadow detector by one sample and queues the results it causes.
  function automatic void detect_spike(logic signed [15:0] x);
    logic signed [15:0] thr;
    bit                 emit;
    spike_result_t      res;
    thr = live_threshold;
    emit = 1'b0;
    if (!est_armed && (cfg_auto_high || cfg_auto_low)) begin
      est_armed = 1'b1;
      est_remaining = cfg_win_len;
      est_count = 0;
      est_sum = 0;
      est_sumsq = 0;
      est_crest = cfg_crest;
      est_negative = cfg_auto_low;
    end
    if (est_armed && est_remaining > 0) begin
      est_sum += x;
      est_sumsq += longint'(x) * longint'(x);
      est_remaining--;
      est_count = (est_count + 1) & 16'hFFFF;
    end
    if (est_armed && est_remaining == 0) begin
      est_armed = 1'b0;
      close_estimate();
    end
    // The crossing test is skipped while a window is pending, on the emitting sample and during refractory time.
    if (countdown > 0) begin
      countdown--;
    end else if (countdown == 0) begin
      emit = 1'b1;
      countdown = -1;
      refractory = stc_pkg::RefractorySamples;
    end else if (refractory != 0) begin
      refractory--;
    end else if (prev_sample > thr && x < thr) begin
      countdown += stc_pkg::PostSamples;
    end
    history[frame_count[stc_pkg::RingAw-1:0]] = x;
    res = '{1'b0, x, 32'd0, 6'd0, !emit || stc_pkg::WinLen == 0};
    expected_results.push_back(res);
    if (emit) begin
      for (int i = 0; i < stc_pkg::WinLen; i++) begin
        res.kind = 1'b1;
        res.sample = history[(frame_count - stc_pkg::WinLen + i) % stc_pkg::RingDepth];
        res.stime = frame_count;
        res.chan = cfg_channel;
        res.last = (i + 1 == stc_pkg::WinLen);
        expected_results.push_back(res);
      end
    end
    frame_count++;
    prev_sample = x;
  endfunction

  // Sample driver: one request per accepted handshake, with random gaps.
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) detect_spike(s_tdata);
      if (!s_tvalid || s_tready) begin
        if (src_gap > 0) begin
          src_gap <= src_gap - 1;
          s_tvalid <= 1'b0;
        end else if (sample_queue.size() > 0) begin
          s_tdata <= sample_queue.pop_front();
          s_tvalid <= 1'b1;
          if (!calm && $urandom_range(0, 7) == 0) src_gap <= $urandom_range(1, 9);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor with random back-pressure; compares against the oldest expectation.
  always @(posedge clk) begin
    spike_result_t want;
    if (!rst) begin
      if (sink_gap > 0) begin
        sink_gap <= sink_gap - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        if (!calm && $urandom_range(0, 7) == 0) sink_gap <= $urandom_range(1, 9);
      end
      if (m_tvalid && m_tready) begin
        if (expected_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected result: kind %0d sample %0d", m_tuser[0],
                     $signed(m_tdata[15:0]));
        end else begin
          want = expected_results.pop_front();
          if (m_tuser[0] !== want.kind || m_tdata[15:0] !== want.sample ||
              m_tdata[47:16] !== want.stime || m_tdata[53:48] !== want.chan ||
              m_tlast !== want.last) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("mismatch: want kind %0d sample %0d time %0d chan %0d last %0d, got %0d %0d %0d %0d %0d",
                       want.kind, want.sample, want.stime, want.chan, want.last,
                       m_tuser[0], $signed(m_tdata[15:0]), m_tdata[47:16],
                       m_tdata[53:48], m_tlast);
          end
        end
      end
    end
  end

  // Watchdog on cycles with no handshake on either stream.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic reg_write(logic [2:0] index, logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {index, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (index)
      stc_pkg::RegThreshold: begin
        cfg_threshold = value[15:0];
        live_threshold = value[15:0];
      end
      stc_pkg::RegAutoHigh: cfg_auto_high = value[0];
      stc_pkg::RegAutoLow:  cfg_auto_low = value[0];
      stc_pkg::RegCrest:    cfg_crest = value[6:0];
      stc_pkg::RegWinLen:   cfg_win_len = value[15:0];
      stc_pkg::RegChannel:  cfg_channel = value[5:0];
      default: ;
    endcase
  endtask

  // Mostly quiet noise with occasional deep dips, so crossings happen often.
  function automatic logic [15:0] spike_sample();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick <= 5) return 16'($signed($urandom_range(0, 2000)) - 1000);
    if (pick <= 7) return 16'(-$signed($urandom_range(4000, 32768)));
    if (pick == 8) return 16'($urandom);
    return 16'($urandom_range(1000, 32767));
  endfunction

  // Sends a batch of random samples and holds the sender until the block drains.
  task automatic run_batch(int count);
    for (int i = 0; i < count; i++) sample_queue.push_back(spike_sample());
    wait (sample_queue.size() == 0 && !s_tvalid && expected_results.size() == 0);
    repeat (SettleCycles) @(posedge clk);
  endtask

  initial begin
    logic [15:0] directed[$];
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Field extremes, values around the reset threshold, and an early crossing
    // whose window reaches back into ring entries never written.
    directed = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 16'h0001, 16'h5555, 16'hAAAA,
                 16'h0000, 16'(-3278), 16'(-3277), 16'(-3276), 16'h0000, 16'(-3277),
                 16'h7FFF, 16'h8000, 16'h1234, 16'hEDCB, 16'h0000, 16'hF000,
                 16'h0FFF, 16'h8001, 16'h7FFE, 16'h0000, 16'h8000};
    foreach (directed[i]) sample_queue.push_back(directed[i]);
    run_batch(40);

    // Thresholds at both ends of the range can never be crossed.
    reg_write(stc_pkg::RegThreshold, 32'h0000_7FFF);
    run_batch(10);
    reg_write(stc_pkg::RegThreshold, 32'hFFFF_8000);
    run_batch(10);

    // Negative automatic threshold over short windows, crest factor 1.0.
    reg_write(stc_pkg::RegThreshold, 32'h0000_0000);
    reg_write(stc_pkg::RegChannel, 32'd48);
    reg_write(stc_pkg::RegCrest, 32'd16);
    reg_write(stc_pkg::RegWinLen, 32'd8);
    reg_write(stc_pkg::RegAutoLow, 32'd1);
    run_batch(60);

    // Positive automatic threshold, one-sample window, crest factor 5.0.
    reg_write(stc_pkg::RegAutoLow, 32'd0);
    reg_write(stc_pkg::RegAutoHigh, 32'd1);
    reg_write(stc_pkg::RegCrest, 32'd80);
    reg_write(stc_pkg::RegWinLen, 32'd1);
    reg_write(stc_pkg::RegChannel, 32'd0);
    run_batch(40);

    // Zero-length window with both enables: estimates end empty and leave the level alone.
    reg_write(stc_pkg::RegWinLen, 32'd0);
    reg_write(stc_pkg::RegAutoLow, 32'd1);
    reg_write(stc_pkg::RegThreshold, 32'hFFFF_F333);
    run_batch(20);

    // Longest window: the estimator stays armed for the rest of the run.
    reg_write(stc_pkg::RegAutoHigh, 32'd0);
    reg_write(stc_pkg::RegWinLen, 32'd65535);
    reg_write(stc_pkg::RegCrest, 32'd37);
    reg_write(stc_pkg::RegChannel, 32'd33);
    run_batch(40);

    // Final stretch runs with no random gaps from either the sender or the sink.
    calm = 1'b1;
    run_batch(40);

    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
